/* rtl/rdm_pkg.sv */
// ----------------------------------------------------------------------------
// rdm_pkg
// Types and constants shared by the RDM frame checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rdm_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STD,
        PH_CS_HI,
        PH_CS_LO,
        PH_PRE,
        PH_DISC
    } phase_t;

    typedef enum logic [1:0] {
        VERD_INVALID,
        VERD_STD,
        VERD_DISC
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } rdm_beat_t;

    typedef struct packed {
        logic        packet_valid;
        logic        packet_kind;
        logic [7:0]  message_length;
        logic [47:0] dst_uid;
        logic [47:0] src_uid;
        logic [7:0]  transaction_number;
        logic [7:0]  port_or_response;
        logic [7:0]  queued_msgs;
        logic [15:0] subdev_id;
        logic [7:0]  command_class;
        logic [15:0] parameter_id;
        logic [7:0]  pd_length;
    } rdm_result_t;

    localparam logic [7:0]  START_CODE      = 8'hCC;
    localparam logic [7:0]  SUB_START_CODE  = 8'h01;
    localparam logic [7:0]  DISC_DELIM      = 8'hAA;
    localparam logic [7:0]  DISC_PREAMBLE   = 8'hFE;
    localparam logic [7:0]  MIN_MSG_LEN     = 8'd24;

    localparam logic [7:0]  IDX_SUB_START   = 8'd1;
    localparam logic [7:0]  IDX_LEN         = 8'd2;
    localparam logic [7:0]  IDX_DEST_FIRST  = 8'd3;
    localparam logic [7:0]  IDX_DEST_LAST   = 8'd8;
    localparam logic [7:0]  IDX_SRC_FIRST   = 8'd9;
    localparam logic [7:0]  IDX_SRC_LAST    = 8'd14;
    localparam logic [7:0]  IDX_HDR_FIRST   = 8'd15;
    localparam logic [7:0]  IDX_HDR_LAST    = 8'd22;
    localparam logic [7:0]  IDX_PD_LEN      = 8'd23;

    localparam logic [7:0]  DISC_ENC_BYTES  = 8'd12;
    localparam logic [7:0]  DISC_LAST_IDX   = 8'd15;

    localparam logic [47:0] DISC_DST_UID    = 48'hFFFF_FFFF_FFFF;
    localparam logic [7:0]  DISC_RESP_ACK   = 8'h00;
    localparam logic [7:0]  DISC_CMD_CLASS  = 8'h11;
    localparam logic [15:0] DISC_PID        = 16'h0001;

endpackage

`default_nettype wire

/* rtl/rdm_in_stage.sv */
// ----------------------------------------------------------------------------
// rdm_in_stage
// Input register: holds one received beat until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_frame_start,
    input  wire logic              s_frame_end,
    output logic                   beat_valid,
    output rdm_pkg::rdm_beat_t     beat,
    input  wire logic              beat_take
);
    import rdm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    rdm_beat_t beat_reg;

    assign s_ready = !valid_reg || beat_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg.data_byte   <= s_data_byte;
            beat_reg.frame_start <= s_frame_start;
            beat_reg.frame_end   <= s_frame_end;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

/* rtl/rdm_frame_fsm.sv */
// ----------------------------------------------------------------------------
// rdm_frame_fsm
// Frame parser: phase machine, header capture, checksums and verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_frame_fsm #(
    parameter int MAX_PREAMBLE = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire rdm_pkg::rdm_beat_t beat,
    output logic                   res_valid,
    output rdm_pkg::rdm_result_t   res
);
    import rdm_pkg::*;

    localparam logic [8:0] MAX_PRE = 9'(MAX_PREAMBLE);

    phase_t      phase_reg, phase_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] rsum_reg, rsum_next;
    logic [7:0]  held_reg, held_next;
    logic [47:0] dest_reg, dest_next;
    logic [47:0] src_reg, src_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [7:0]  pdl_reg, pdl_next;
    logic [7:0]  len_reg, len_next;

    logic [7:0]  b;
    logic [8:0]  idx_inc;
    logic [7:0]  len_cur;
    logic        std_to_cs;
    logic [7:0]  and_byte;
    logic [15:0] disc_rsum;
    logic        emit;
    logic        chk_end;
    verdict_t    verdict;

    assign b         = beat.data_byte;
    assign idx_inc   = {1'b0, idx_reg} + 9'd1;
    assign len_cur   = (idx_reg == IDX_LEN) ? b : len_reg;
    assign std_to_cs = (idx_reg >= IDX_LEN) && (idx_inc == {1'b0, len_cur});
    assign and_byte  = held_reg & b;
    assign disc_rsum = {rsum_reg[7:0], and_byte};

    // phase and verdict
    always_comb begin
        phase_next = phase_reg;
        emit       = 1'b0;
        chk_end    = 1'b0;
        verdict    = VERD_INVALID;
        if (fire) begin
            if (beat.frame_start) begin
                chk_end = 1'b1;
                if (b == START_CODE) begin
                    phase_next = PH_STD;
                end else if (b == DISC_DELIM) begin
                    phase_next = PH_DISC;
                end else if (b == DISC_PREAMBLE) begin
                    phase_next = PH_PRE;
                    if (9'd1 > MAX_PRE) begin
                        emit = 1'b1;
                    end
                end else begin
                    emit = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_STD: begin
                        chk_end = 1'b1;
                        if (idx_reg == IDX_SUB_START && b != SUB_START_CODE) begin
                            emit = 1'b1;
                        end else if (idx_reg == IDX_LEN && b < MIN_MSG_LEN) begin
                            emit = 1'b1;
                        end else if (std_to_cs) begin
                            phase_next = PH_CS_HI;
                        end
                    end
                    PH_CS_HI: begin
                        chk_end    = 1'b1;
                        phase_next = PH_CS_LO;
                    end
                    PH_CS_LO: begin
                        emit = 1'b1;
                        if ({rsum_reg[15:8], b} == sum_reg) begin
                            verdict = VERD_STD;
                        end
                    end
                    PH_PRE: begin
                        chk_end = 1'b1;
                        if (b == DISC_DELIM) begin
                            phase_next = PH_DISC;
                        end else if (idx_inc > MAX_PRE) begin
                            emit = 1'b1;
                        end
                    end
                    PH_DISC: begin
                        chk_end = 1'b1;
                        if (idx_reg >= DISC_LAST_IDX) begin
                            emit = 1'b1;
                            if (disc_rsum == sum_reg) begin
                                verdict = VERD_DISC;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (chk_end && !emit && beat.frame_end) begin
                emit    = 1'b1;
                verdict = VERD_INVALID;
            end
            if (emit) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // header and checksum datapath
    always_comb begin
        idx_next  = idx_reg;
        sum_next  = sum_reg;
        rsum_next = rsum_reg;
        held_next = held_reg;
        dest_next = dest_reg;
        src_next  = src_reg;
        hdr_next  = hdr_reg;
        pdl_next  = pdl_reg;
        len_next  = len_reg;
        if (fire) begin
            if (beat.frame_start) begin
                idx_next  = '0;
                sum_next  = '0;
                rsum_next = '0;
                held_next = '0;
                dest_next = '0;
                src_next  = '0;
                hdr_next  = '0;
                pdl_next  = '0;
                len_next  = '0;
                if (b == START_CODE) begin
                    idx_next = 8'd1;
                    sum_next = {8'h00, b};
                end else if (b == DISC_PREAMBLE) begin
                    idx_next = 8'd1;
                end
            end else begin
                unique case (phase_reg)
                    PH_STD: begin
                        sum_next = sum_reg + {8'h00, b};
                        if (idx_reg == IDX_LEN) begin
                            len_next = b;
                        end else if (idx_reg >= IDX_DEST_FIRST && idx_reg <= IDX_DEST_LAST) begin
                            dest_next = {dest_reg[39:0], b};
                        end else if (idx_reg >= IDX_SRC_FIRST && idx_reg <= IDX_SRC_LAST) begin
                            src_next = {src_reg[39:0], b};
                        end else if (idx_reg >= IDX_HDR_FIRST && idx_reg <= IDX_HDR_LAST) begin
                            hdr_next = {hdr_reg[55:0], b};
                        end else if (idx_reg == IDX_PD_LEN) begin
                            pdl_next = b;
                        end
                        if (!std_to_cs) begin
                            idx_next = idx_inc[7:0];
                        end
                    end
                    PH_CS_HI: begin
                        rsum_next = {b, 8'h00};
                    end
                    PH_CS_LO: begin
                        rsum_next = {rsum_reg[15:8], b};
                    end
                    PH_PRE: begin
                        if (b == DISC_DELIM) begin
                            idx_next = '0;
                        end else begin
                            idx_next = idx_inc[7:0];
                        end
                    end
                    PH_DISC: begin
                        if (idx_reg < DISC_ENC_BYTES) begin
                            sum_next = sum_reg + {8'h00, b};
                        end
                        if (!idx_reg[0]) begin
                            held_next = b;
                        end else if (idx_reg < DISC_ENC_BYTES) begin
                            src_next = {src_reg[39:0], and_byte};
                        end else begin
                            rsum_next = disc_rsum;
                        end
                        idx_next = idx_inc[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result fields
    always_comb begin
        res = '0;
        unique case (verdict)
            VERD_STD: begin
                res.packet_valid       = 1'b1;
                res.packet_kind        = 1'b0;
                res.message_length     = len_reg;
                res.dst_uid            = dest_reg;
                res.src_uid            = src_reg;
                res.transaction_number = hdr_reg[63:56];
                res.port_or_response   = hdr_reg[55:48];
                res.queued_msgs        = hdr_reg[47:40];
                res.subdev_id          = hdr_reg[39:24];
                res.command_class      = hdr_reg[23:16];
                res.parameter_id       = hdr_reg[15:0];
                res.pd_length          = pdl_reg;
            end
            VERD_DISC: begin
                res.packet_valid     = 1'b1;
                res.packet_kind      = 1'b1;
                res.dst_uid          = DISC_DST_UID;
                res.src_uid          = src_reg;
                res.port_or_response = DISC_RESP_ACK;
                res.command_class    = DISC_CMD_CLASS;
                res.parameter_id     = DISC_PID;
            end
            default: begin
            end
        endcase
    end

    assign res_valid = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        rsum_reg <= rsum_next;
        held_reg <= held_next;
        dest_reg <= dest_next;
        src_reg  <= src_next;
        hdr_reg  <= hdr_next;
        pdl_reg  <= pdl_next;
        len_reg  <= len_next;
    end

endmodule

`default_nettype wire

/* rtl/rdm_out_stage.sv */
// ----------------------------------------------------------------------------
// rdm_out_stage
// Result register: holds one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 res_valid,
    input  wire rdm_pkg::rdm_result_t res,
    output logic                      res_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rdm_pkg::rdm_result_t      m_res
);
    import rdm_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    rdm_result_t res_reg;

    assign res_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

/* rtl/rdm_packet_header_parser.sv */
// path: the deciding beat is held in the input register, then its verdict in the result register
// throughput: one beat per cycle, sustained while the result side keeps up
// the rate is set by the single input register and single result register
// reset: synchronous active-low aresetn; parser returns to idle, both stages empty
// ----------------------------------------------------------------------------
// rdm_packet_header_parser
// Byte-wise RDM frame checker with header field extraction.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_packet_header_parser #(
    parameter int MAX_PREAMBLE = 7
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_frame_start,
    input  wire logic        s_frame_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_packet_valid,
    output logic             m_packet_kind,
    output logic [7:0]       m_message_length,
    output logic [47:0]      m_dst_uid,
    output logic [47:0]      m_src_uid,
    output logic [7:0]       m_transaction_number,
    output logic [7:0]       m_port_or_response,
    output logic [7:0]       m_queued_msgs,
    output logic [15:0]      m_subdev_id,
    output logic [7:0]       m_command_class,
    output logic [15:0]      m_parameter_id,
    output logic [7:0]       m_pd_length
);
    import rdm_pkg::*;

    logic        beat_valid;
    rdm_beat_t   beat;
    logic        res_ready;
    logic        fire;
    logic        res_valid;
    rdm_result_t res;
    rdm_result_t m_res;

    assign fire = beat_valid && res_ready;

    rdm_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_start (s_frame_start),
        .s_frame_end   (s_frame_end),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .beat_take     (fire)
    );

    rdm_frame_fsm #(
        .MAX_PREAMBLE (MAX_PREAMBLE)
    ) u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    rdm_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_packet_valid       = m_res.packet_valid;
    assign m_packet_kind        = m_res.packet_kind;
    assign m_message_length     = m_res.message_length;
    assign m_dst_uid            = m_res.dst_uid;
    assign m_src_uid            = m_res.src_uid;
    assign m_transaction_number = m_res.transaction_number;
    assign m_port_or_response   = m_res.port_or_response;
    assign m_queued_msgs        = m_res.queued_msgs;
    assign m_subdev_id          = m_res.subdev_id;
    assign m_command_class      = m_res.command_class;
    assign m_parameter_id       = m_res.parameter_id;
    assign m_pd_length          = m_res.pd_length;

endmodule

`default_nettype wire

/* tb/sv/rdm_packet_header_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdm_packet_header_parser_tb
// Feeds RDM frames into the checker one byte per beat and compares every
// verdict, field by field, with a byte-wise model of the frame checker.
// A short table of edge cases runs first. Random frames follow: well-formed
// standard packets and discovery responses, bad checksums, cut and restarted
// frames, and noise. Both sides stall at random, and the result side holds off
// once for a long stretch so the checker fills up and stalls its input.
// ----------------------------------------------------------------------------

module rdm_packet_header_parser_tb;

    import rdm_pkg::*;

    localparam int PREAMBLE_LIMIT = 7;
    localparam int RANDOM_BEATS   = 425;
    localparam int HOLD_AFTER     = 12;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_INVALID
    } check_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        check_t     chk;
    } probe_t;

    localparam int PROBES = 25;
    localparam probe_t DIRECTED [PROBES] = '{
        '{8'h00, 1'b1, 1'b0, CHK_INVALID},  // bad start code
        '{8'hFF, 1'b1, 1'b1, CHK_INVALID},
        '{8'h55, 1'b0, 1'b0, CHK_NONE},     // outside any frame
        '{8'hCC, 1'b1, 1'b0, CHK_MODEL},
        '{8'h02, 1'b0, 1'b0, CHK_INVALID},  // bad sub start code
        '{8'hCC, 1'b1, 1'b0, CHK_MODEL},
        '{8'h01, 1'b0, 1'b0, CHK_MODEL},
        '{8'h17, 1'b0, 1'b0, CHK_INVALID},  // length below minimum
        '{8'hCC, 1'b1, 1'b0, CHK_MODEL},
        '{8'h01, 1'b0, 1'b0, CHK_MODEL},
        '{8'hFF, 1'b0, 1'b0, CHK_MODEL},
        '{8'h12, 1'b0, 1'b1, CHK_INVALID},  // early end
        '{8'hAA, 1'b1, 1'b0, CHK_MODEL},
        '{8'hCC, 1'b1, 1'b0, CHK_MODEL},    // restart drops discovery frame
        '{8'h01, 1'b0, 1'b1, CHK_INVALID},
        '{8'hFE, 1'b1, 1'b0, CHK_MODEL},
        '{8'h00, 1'b0, 1'b0, CHK_MODEL},
        '{8'hFF, 1'b0, 1'b0, CHK_MODEL},
        '{8'hFE, 1'b0, 1'b0, CHK_MODEL},
        '{8'h01, 1'b0, 1'b0, CHK_MODEL},
        '{8'h80, 1'b0, 1'b0, CHK_MODEL},
        '{8'h7F, 1'b0, 1'b0, CHK_MODEL},
        '{8'h55, 1'b0, 1'b0, CHK_INVALID},  // preamble too long
        '{8'h77, 1'b0, 1'b1, CHK_NONE},     // after verdict
        '{8'hFE, 1'b1, 1'b1, CHK_INVALID}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_frame_start;
    logic        s_frame_end;
    logic        m_valid;
    logic        m_ready;
    logic        m_packet_valid;
    logic        m_packet_kind;
    logic [7:0]  m_message_length;
    logic [47:0] m_dst_uid;
    logic [47:0] m_src_uid;
    logic [7:0]  m_transaction_number;
    logic [7:0]  m_port_or_response;
    logic [7:0]  m_queued_msgs;
    logic [15:0] m_subdev_id;
    logic [7:0]  m_command_class;
    logic [15:0] m_parameter_id;
    logic [7:0]  m_pd_length;

    rdm_packet_header_parser #(
        .MAX_PREAMBLE(PREAMBLE_LIMIT)
    ) u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_data_byte          (s_data_byte),
        .s_frame_start        (s_frame_start),
        .s_frame_end          (s_frame_end),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_packet_valid       (m_packet_valid),
        .m_packet_kind        (m_packet_kind),
        .m_message_length     (m_message_length),
        .m_dst_uid            (m_dst_uid),
        .m_src_uid            (m_src_uid),
        .m_transaction_number (m_transaction_number),
        .m_port_or_response   (m_port_or_response),
        .m_queued_msgs        (m_queued_msgs),
        .m_subdev_id          (m_subdev_id),
        .m_command_class      (m_command_class),
        .m_parameter_id       (m_parameter_id),
        .m_pd_length          (m_pd_length)
    );

    // frame checker state mirrored byte by byte
    phase_t      fr_phase;
    logic [7:0]  fr_idx;
    logic [15:0] fr_sum;
    logic [15:0] fr_rx_sum;
    logic [7:0]  fr_held;
    logic [7:0]  fr_len;
    logic [47:0] fr_dest;
    logic [47:0] fr_src;
    logic [63:0] fr_hdr;
    logic [7:0]  fr_pdlen;

    rdm_result_t verdict_q [$];
    rdm_beat_t   frame_q [$];
    rdm_result_t head_verdict;

    int  errors        = 0;
    int  results_taken = 0;
    int  live_beats    = 0;
    int  beats_sent    = 0;
    int  std_ok        = 0;
    int  disc_ok       = 0;
    int  bad_verdicts  = 0;
    int  frames_built  = 0;
    int  cycle_count   = 0;
    bit  src_burst     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic clear_judge();
        fr_phase  = PH_IDLE;
        fr_idx    = 8'd0;
        fr_sum    = 16'd0;
        fr_rx_sum = 16'd0;
        fr_held   = 8'd0;
        fr_len    = 8'd0;
        fr_dest   = 48'd0;
        fr_src    = 48'd0;
        fr_hdr    = 64'd0;
        fr_pdlen  = 8'd0;
    endtask

    task automatic judge_byte(input logic [7:0] b, input logic st, input logic en,
                              output logic got, output rdm_result_t res,
                              output logic skipped);
        logic [7:0] i;
        logic       decided;
        verdict_t   v;
        got     = 1'b0;
        skipped = 1'b0;
        decided = 1'b0;
        v       = VERD_INVALID;
        res     = '0;
        i       = fr_idx;
        if (st) begin
            clear_judge();
            case (b)
                START_CODE: begin
                    fr_phase = PH_STD;
                    fr_idx   = 8'd1;
                    fr_sum   = {8'h00, b};
                end
                DISC_DELIM: fr_phase = PH_DISC;
                DISC_PREAMBLE: begin
                    fr_phase = PH_PRE;
                    fr_idx   = 8'd1;
                    decided  = (PREAMBLE_LIMIT < 1);
                end
                default: decided = 1'b1;
            endcase
        end else begin
            case (fr_phase)
                PH_STD: begin
                    fr_sum = fr_sum + {8'h00, b};
                    if (i == IDX_SUB_START && b != SUB_START_CODE) begin
                        decided = 1'b1;
                    end else if (i == IDX_LEN && b < MIN_MSG_LEN) begin
                        decided = 1'b1;
                    end else begin
                        if (i == IDX_LEN)
                            fr_len = b;
                        else if (i >= IDX_DEST_FIRST && i <= IDX_DEST_LAST)
                            fr_dest = {fr_dest[39:0], b};
                        else if (i >= IDX_SRC_FIRST && i <= IDX_SRC_LAST)
                            fr_src = {fr_src[39:0], b};
                        else if (i >= IDX_HDR_FIRST && i <= IDX_HDR_LAST)
                            fr_hdr = {fr_hdr[55:0], b};
                        else if (i == IDX_PD_LEN)
                            fr_pdlen = b;
                        if (i >= IDX_LEN && {1'b0, i} + 9'd1 == {1'b0, fr_len})
                            fr_phase = PH_CS_HI;
                        else
                            fr_idx = i + 8'd1;
                    end
                end
                PH_CS_HI: begin
                    fr_rx_sum = {b, 8'h00};
                    fr_phase  = PH_CS_LO;
                end
                PH_CS_LO: begin
                    fr_rx_sum[7:0] = b;
                    decided = 1'b1;
                    if (fr_rx_sum == fr_sum)
                        v = VERD_STD;
                end
                PH_PRE: begin
                    if (b == DISC_DELIM) begin
                        fr_phase = PH_DISC;
                        fr_idx   = 8'd0;
                    end else begin
                        fr_idx  = i + 8'd1;
                        decided = (int'(fr_idx) > PREAMBLE_LIMIT);
                    end
                end
                PH_DISC: begin
                    if (i < DISC_ENC_BYTES)
                        fr_sum = fr_sum + {8'h00, b};
                    if (!i[0])
                        fr_held = b;
                    else if (i < DISC_ENC_BYTES)
                        fr_src = {fr_src[39:0], fr_held & b};
                    else
                        fr_rx_sum = {fr_rx_sum[7:0], fr_held & b};
                    if (i >= DISC_LAST_IDX) begin
                        decided = 1'b1;
                        if (fr_rx_sum == fr_sum)
                            v = VERD_DISC;
                    end else begin
                        fr_idx = i + 8'd1;
                    end
                end
                default: skipped = 1'b1;
            endcase
        end
        // an undecided frame that ends here is invalid
        if (!skipped && (decided || en)) begin
            got = 1'b1;
            if (v == VERD_STD) begin
                res.packet_valid       = 1'b1;
                res.message_length     = fr_len;
                res.dst_uid            = fr_dest;
                res.src_uid            = fr_src;
                res.transaction_number = fr_hdr[63:56];
                res.port_or_response   = fr_hdr[55:48];
                res.queued_msgs        = fr_hdr[47:40];
                res.subdev_id          = fr_hdr[39:24];
                res.command_class      = fr_hdr[23:16];
                res.parameter_id       = fr_hdr[15:0];
                res.pd_length          = fr_pdlen;
            end else if (v == VERD_DISC) begin
                res.packet_valid     = 1'b1;
                res.packet_kind      = 1'b1;
                res.dst_uid          = DISC_DST_UID;
                res.src_uid          = fr_src;
                res.port_or_response = DISC_RESP_ACK;
                res.command_class    = DISC_CMD_CLASS;
                res.parameter_id     = DISC_PID;
            end
            fr_phase = PH_IDLE;
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic st, input logic en,
                             input check_t chk);
        int          gap;
        logic        got;
        logic        skipped;
        rdm_result_t res;
        gap = draw_gap(src_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_frame_start <= st;
        s_frame_end   <= en;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        judge_byte(b, st, en, got, res, skipped);
        if (!skipped)
            live_beats++;
        if (chk == CHK_INVALID) begin
            got = 1'b1;
            res = '0;
        end else if (chk == CHK_NONE) begin
            got = 1'b0;
        end
        if (got) begin
            verdict_q.push_back(res);
            if (!res.packet_valid)
                bad_verdicts++;
            else if (res.packet_kind)
                disc_ok++;
            else
                std_ok++;
        end
        @(negedge aclk);
    endtask

    task automatic add_beat(input logic [7:0] b, input logic st, input logic en);
        rdm_beat_t beat;
        beat.data_byte   = b;
        beat.frame_start = st;
        beat.frame_end   = en;
        frame_q.push_back(beat);
    endtask

    task automatic build_frame();
        int          pick;
        int          k;
        int          npre;
        logic [7:0]  len;
        logic [7:0]  bt;
        logic [7:0]  e0;
        logic [7:0]  e1;
        logic [15:0] sum;
        rdm_beat_t   tail;
        frame_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            sum = 16'd0;
            if (pick < 45) begin
                len = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(24, 36));
                for (k = 0; k < int'(len); k++) begin
                    bt = (k == 0) ? START_CODE : (k == 1) ? SUB_START_CODE :
                         (k == 2) ? len : 8'($urandom);
                    sum = sum + {8'h00, bt};
                    add_beat(bt, k == 0, 1'b0);
                end
                if (pick >= 38)
                    sum = sum ^ (16'd1 << $urandom_range(0, 15));
                add_beat(sum[15:8], 1'b0, 1'b0);
                add_beat(sum[7:0], 1'b0, 1'($urandom_range(0, 1)));
            end else begin
                npre = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(0, PREAMBLE_LIMIT);
                for (k = 0; k < npre; k++) begin
                    bt = (k == 0) ? DISC_PREAMBLE : 8'($urandom);
                    if (bt == DISC_DELIM)
                        bt = DISC_PREAMBLE;
                    add_beat(bt, k == 0, 1'b0);
                end
                add_beat(DISC_DELIM, npre == 0, 1'b0);
                for (k = 0; k < 6; k++) begin
                    bt = 8'($urandom);
                    if ($urandom_range(0, 1)) begin
                        e0 = bt | 8'hAA;
                        e1 = bt | 8'h55;
                    end else begin
                        e0 = 8'($urandom);
                        e1 = 8'($urandom);
                    end
                    sum = sum + {8'h00, e0} + {8'h00, e1};
                    add_beat(e0, 1'b0, 1'b0);
                    add_beat(e1, 1'b0, 1'b0);
                end
                if (pick >= 72)
                    sum = sum ^ (16'd1 << $urandom_range(0, 15));
                add_beat(sum[15:8] | 8'hAA, 1'b0, 1'b0);
                add_beat(sum[15:8] | 8'h55, 1'b0, 1'b0);
                add_beat(sum[7:0] | 8'hAA, 1'b0, 1'b0);
                add_beat(sum[7:0] | 8'h55, 1'b0, 1'($urandom_range(0, 1)));
            end
            // cut short; without an end marker the next frame restarts it
            if (pick % 4 == 0) begin
                k = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > k)
                    tail = frame_q.pop_back();
                tail = frame_q.pop_back();
                tail.frame_end = ($urandom_range(0, 3) != 0);
                frame_q.push_back(tail);
            end
            if ($urandom_range(0, 4) == 0)
                add_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
        end else begin
            npre = $urandom_range(1, 4);
            for (k = 0; k < npre; k++)
                add_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want,
                         seen);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected verdict, expected none, actual valid %0b kind %0b",
                             $time, m_packet_valid, m_packet_kind);
            end else begin
                head_verdict = verdict_q.pop_front();
                check_field("packet_valid", 64'(head_verdict.packet_valid),
                            64'(m_packet_valid));
                check_field("packet_kind", 64'(head_verdict.packet_kind),
                            64'(m_packet_kind));
                check_field("message_length", 64'(head_verdict.message_length),
                            64'(m_message_length));
                check_field("dst_uid", 64'(head_verdict.dst_uid), 64'(m_dst_uid));
                check_field("src_uid", 64'(head_verdict.src_uid), 64'(m_src_uid));
                check_field("transaction_number", 64'(head_verdict.transaction_number),
                            64'(m_transaction_number));
                check_field("port_or_response", 64'(head_verdict.port_or_response),
                            64'(m_port_or_response));
                check_field("queued_msgs", 64'(head_verdict.queued_msgs),
                            64'(m_queued_msgs));
                check_field("subdev_id", 64'(head_verdict.subdev_id), 64'(m_subdev_id));
                check_field("command_class", 64'(head_verdict.command_class),
                            64'(m_command_class));
                check_field("parameter_id", 64'(head_verdict.parameter_id),
                            64'(m_parameter_id));
                check_field("pd_length", 64'(head_verdict.pd_length), 64'(m_pd_length));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
            $display("rdm_packet_header_parser test failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin : sink
        int gap;
        bit burst;
        bit held;
        burst   = 1'b0;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = draw_gap(burst);
            if (!held && results_taken >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = LONG_HOLD;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin : source
        int        rand_base;
        rdm_beat_t beat;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = 8'd0;
        s_frame_start = 1'b0;
        s_frame_end   = 1'b0;
        clear_judge();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < PROBES; r++)
            send_beat(DIRECTED[r].data, DIRECTED[r].first, DIRECTED[r].last, DIRECTED[r].chk);

        rand_base = beats_sent;
        while ((beats_sent - rand_base) < RANDOM_BEATS) begin
            build_frame();
            frames_built++;
            while (frame_q.size() != 0 && (beats_sent - rand_base) < RANDOM_BEATS) begin
                beat = frame_q.pop_front();
                send_beat(beat.data_byte, beat.frame_start, beat.frame_end, CHK_MODEL);
            end
        end
        s_valid <= 1'b0;

        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d beats (%0d inside frames): %0d table rows, %0d generated frames",
                 beats_sent, live_beats, PROBES, frames_built);
        $display("verdicts: %0d standard ok, %0d discovery ok, %0d invalid, %0d field errors",
                 std_ok, disc_ok, bad_verdicts, errors);
        if (errors == 0)
            $display("rdm_packet_header_parser test passed");
        else
            $display("rdm_packet_header_parser test failed");
        $finish;
    end

endmodule
